// File: src/wsa_pkg.sv
package wsa_pkg;

  localparam int MAX_SAMPLES = 1023;

  // sample counter and derived accumulator widths
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int VSUM_W = 13 + CNT_W;
  localparam int PSUM_W = 16 + CNT_W;
  localparam int TSUM_W = 16 + CNT_W;
  localparam int HSUM_W = 14 + CNT_W;
  localparam int CSUM_W = 16 + CNT_W;
  localparam int DVD_W  = 16 + CNT_W;
  localparam int SAMP_W = 10;
  localparam int AVG_W  = 16;
  localparam int NUM_CH = 8;

  localparam logic ACT_ACC   = 1'b0;
  localparam logic ACT_CLOSE = 1'b1;

  // channel slots of the average store, in output order
  localparam logic [2:0] CH_VOC  = 3'd0;
  localparam logic [2:0] CH_PM1  = 3'd1;
  localparam logic [2:0] CH_PM25 = 3'd2;
  localparam logic [2:0] CH_PM4  = 3'd3;
  localparam logic [2:0] CH_PM10 = 3'd4;
  localparam logic [2:0] CH_TEMP = 3'd5;
  localparam logic [2:0] CH_HUM  = 3'd6;
  localparam logic [2:0] CH_CO2  = 3'd7;

  typedef struct packed {
    logic               action;
    logic               group_one_valid;
    logic [12:0]        voc_index;
    logic [15:0]        pm_one;
    logic [15:0]        pm_two_five;
    logic [15:0]        pm_four;
    logic [15:0]        pm_ten;
    logic signed [15:0] temperature;
    logic [13:0]        humidity;
    logic               group_two_valid;
    logic [15:0]        carbon_dioxide;
  } in_item_t;

  typedef struct packed {
    logic [12:0]        avg_voc;
    logic [15:0]        avg_pm_one;
    logic [15:0]        avg_pm_two_five;
    logic [15:0]        avg_pm_four;
    logic [15:0]        avg_pm_ten;
    logic signed [15:0] avg_temperature;
    logic [13:0]        avg_humidity;
    logic [15:0]        avg_co2;
    logic [9:0]         samples_one;
    logic [9:0]         samples_two;
  } out_item_t;

  typedef struct packed {
    logic       acc;
    logic       div_start;
    logic       avg_wr;
    logic       emit;
    logic [2:0] idx;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// File: src/wsa_div.sv
module wsa_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [wsa_pkg::DVD_W-1:0] dividend,
  input  logic [wsa_pkg::CNT_W-1:0] divisor,
  output logic                      done,
  output logic [wsa_pkg::DVD_W-1:0] quotient
);
  import wsa_pkg::*;

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  rem_nxt;
  logic [DVD_W-1:0]  quo_r;
  logic [DVD_W-1:0]  quo_nxt;
  logic [CNT_W-1:0]  div_r;
  logic [CNT_W:0]    shifted;
  logic              ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    shifted = {rem_r, quo_r[DVD_W-1]};
    ge      = shifted >= {1'b0, div_r};
    rem_nxt = ge ? CNT_W'(shifted - {1'b0, div_r}) : CNT_W'(shifted);
    quo_nxt = {quo_r[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= STEP_W'(DVD_W);
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      cnt_r <= cnt_r - STEP_W'(1);
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: src/wsa_dp.sv
module wsa_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  wsa_pkg::in_item_t  in_data,
  input  wsa_pkg::cmd_t      cmd,
  output wsa_pkg::sts_t      sts,
  output logic               out_valid,
  input  logic               out_stall,
  output wsa_pkg::out_item_t out_data
);
  import wsa_pkg::*;

  logic [VSUM_W-1:0]        sum_voc_r;
  logic [PSUM_W-1:0]        sum_pm_r [4];
  logic signed [TSUM_W-1:0] sum_temp_r;
  logic [HSUM_W-1:0]        sum_hum_r;
  logic [CSUM_W-1:0]        sum_co2_r;
  logic [CNT_W-1:0]         count_one_r;
  logic [CNT_W-1:0]         count_two_r;
  logic [AVG_W-1:0]         last_avg_r [NUM_CH];
  logic                     out_valid_r;
  out_item_t                out_data_r;

  logic              temp_neg;
  logic [TSUM_W-1:0] temp_mag;
  logic [DVD_W-1:0]  dividend;
  logic [CNT_W-1:0]  divisor;
  logic              div_done;
  logic [DVD_W-1:0]  quotient;
  logic [AVG_W-1:0]  quo_avg;
  logic [AVG_W-1:0]  wr_val;
  logic              one_take;
  logic              two_take;
  logic              out_free;

  assign temp_neg = sum_temp_r[TSUM_W-1];
  assign temp_mag = temp_neg ? TSUM_W'(-sum_temp_r) : TSUM_W'(sum_temp_r);

  always_comb begin
    case (cmd.idx)
      CH_VOC:  dividend = DVD_W'(sum_voc_r);
      CH_PM1:  dividend = DVD_W'(sum_pm_r[0]);
      CH_PM25: dividend = DVD_W'(sum_pm_r[1]);
      CH_PM4:  dividend = DVD_W'(sum_pm_r[2]);
      CH_PM10: dividend = DVD_W'(sum_pm_r[3]);
      CH_TEMP: dividend = DVD_W'(temp_mag);
      CH_HUM:  dividend = DVD_W'(sum_hum_r);
      CH_CO2:  dividend = DVD_W'(sum_co2_r);
      default: dividend = '0;
    endcase
  end

  assign divisor = (cmd.idx == CH_CO2) ? count_two_r : count_one_r;

  wsa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // temperature divides as a magnitude; sign restored here
  assign quo_avg = AVG_W'(quotient);
  assign wr_val  = (cmd.idx == CH_TEMP && temp_neg) ? AVG_W'(-quo_avg) : quo_avg;

  assign one_take = cmd.acc && in_data.group_one_valid
                    && (count_one_r < CNT_W'(MAX_SAMPLES));
  assign two_take = cmd.acc && in_data.group_two_valid
                    && (count_two_r < CNT_W'(MAX_SAMPLES));
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_voc_r   <= '0;
      sum_pm_r    <= '{default: '0};
      sum_temp_r  <= '0;
      sum_hum_r   <= '0;
      sum_co2_r   <= '0;
      count_one_r <= '0;
      count_two_r <= '0;
      last_avg_r  <= '{default: '0};
    end else begin
      if (one_take) begin
        sum_voc_r   <= sum_voc_r + VSUM_W'(in_data.voc_index);
        sum_pm_r[0] <= sum_pm_r[0] + PSUM_W'(in_data.pm_one);
        sum_pm_r[1] <= sum_pm_r[1] + PSUM_W'(in_data.pm_two_five);
        sum_pm_r[2] <= sum_pm_r[2] + PSUM_W'(in_data.pm_four);
        sum_pm_r[3] <= sum_pm_r[3] + PSUM_W'(in_data.pm_ten);
        sum_temp_r  <= sum_temp_r + TSUM_W'(in_data.temperature);
        sum_hum_r   <= sum_hum_r + HSUM_W'(in_data.humidity);
        count_one_r <= count_one_r + CNT_W'(1);
      end
      if (two_take) begin
        sum_co2_r   <= sum_co2_r + CSUM_W'(in_data.carbon_dioxide);
        count_two_r <= count_two_r + CNT_W'(1);
      end
      if (cmd.avg_wr) begin
        last_avg_r[cmd.idx] <= wr_val;
      end
      if (cmd.emit) begin
        sum_voc_r   <= '0;
        sum_pm_r    <= '{default: '0};
        sum_temp_r  <= '0;
        sum_hum_r   <= '0;
        sum_co2_r   <= '0;
        count_one_r <= '0;
        count_two_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.avg_voc         <= 13'(last_avg_r[CH_VOC]);
      out_data_r.avg_pm_one      <= last_avg_r[CH_PM1];
      out_data_r.avg_pm_two_five <= last_avg_r[CH_PM25];
      out_data_r.avg_pm_four     <= last_avg_r[CH_PM4];
      out_data_r.avg_pm_ten      <= last_avg_r[CH_PM10];
      out_data_r.avg_temperature <= last_avg_r[CH_TEMP];
      out_data_r.avg_humidity    <= 14'(last_avg_r[CH_HUM]);
      out_data_r.avg_co2         <= last_avg_r[CH_CO2];
      out_data_r.samples_one     <= SAMP_W'(count_one_r);
      out_data_r.samples_two     <= SAMP_W'(count_two_r);
    end
  end

  assign sts.skip     = (divisor == '0);
  assign sts.div_done = div_done;
  assign sts.out_free = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: src/wsa_ctrl.sv
module wsa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          action,
  output logic          in_stall,
  input  wsa_pkg::sts_t sts,
  output wsa_pkg::cmd_t cmd
);
  import wsa_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic [2:0] idx_r;
  logic [2:0] idx_nxt;
  logic       take;

  assign in_stall = (state_r != ST_IDLE);
  assign take     = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cmd.acc       = 1'b0;
    cmd.div_start = 1'b0;
    cmd.avg_wr    = 1'b0;
    cmd.emit      = 1'b0;
    cmd.idx       = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (take && action == ACT_ACC) begin
          cmd.acc = 1'b1;
        end else if (take && action == ACT_CLOSE) begin
          idx_nxt   = CH_VOC;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // empty group keeps its previous average
        if (sts.skip) begin
          if (idx_r == CH_CO2) begin
            state_nxt = ST_EMIT;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (sts.div_done) begin
          cmd.avg_wr = 1'b1;
          if (idx_r == CH_CO2) begin
            state_nxt = ST_EMIT;
          end else begin
            idx_nxt   = idx_r + 3'd1;
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= CH_VOC;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// File: src/windowed_sensor_averager_unit.sv
// Accumulate request: taken while idle; the next request may follow at once.
// Close request: one shared restoring divider serves the eight channels in turn and
// skips empty ones, which keep their averages; the output register is then loaded
// once it is free. A held result does not block accumulate requests; a second
// close waits for it. Synchronous active-low reset zeroes all sums, counts and kept averages.
module windowed_sensor_averager_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wsa_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output wsa_pkg::out_item_t out_data
);
  import wsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .action   (in_data.action),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  wsa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: src/wsa_chk.sv
module wsa_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input wsa_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input wsa_pkg::out_item_t out_data
);
  import wsa_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_acc_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.action == ACT_ACC && !out_valid |=> !out_valid)
    else $error("accumulate request produced a result");

  a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.action == ACT_CLOSE |=> in_stall)
    else $error("close request did not occupy the block");

endmodule

bind windowed_sensor_averager_unit wsa_chk u_chk (.*);

// File: verif/wsa_average_checker.sv
`timescale 1ns / 1ps

module wsa_average_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  wsa_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  wsa_pkg::out_item_t out_data,
  output int                 mismatch_count,
  output int                 awaited_count
);
  import wsa_pkg::*;

  logic [VSUM_W-1:0]        voc_sum;
  logic [PSUM_W-1:0]        pm_sum [4];
  logic signed [TSUM_W-1:0] temp_sum;
  logic [HSUM_W-1:0]        hum_sum;
  logic [CSUM_W-1:0]        co2_sum;
  logic [CNT_W-1:0]         cnt_one;
  logic [CNT_W-1:0]         cnt_two;
  out_item_t                kept_avgs;
  out_item_t                pending_averages [$];
  int                       misses;

  assign mismatch_count = misses;

  task automatic clear_sums();
    voc_sum  = '0;
    for (int i = 0; i < 4; i++) pm_sum[i] = '0;
    temp_sum = '0;
    hum_sum  = '0;
    co2_sum  = '0;
    cnt_one  = '0;
    cnt_two  = '0;
  endtask

  task automatic fold_sample(input in_item_t req);
    // a full counter drops further samples of its group
    if (req.group_one_valid && cnt_one < CNT_W'(MAX_SAMPLES)) begin
      voc_sum   = voc_sum + VSUM_W'(req.voc_index);
      pm_sum[0] = pm_sum[0] + PSUM_W'(req.pm_one);
      pm_sum[1] = pm_sum[1] + PSUM_W'(req.pm_two_five);
      pm_sum[2] = pm_sum[2] + PSUM_W'(req.pm_four);
      pm_sum[3] = pm_sum[3] + PSUM_W'(req.pm_ten);
      temp_sum  = temp_sum + TSUM_W'(req.temperature);
      hum_sum   = hum_sum + HSUM_W'(req.humidity);
      cnt_one   = cnt_one + CNT_W'(1);
    end
    if (req.group_two_valid && cnt_two < CNT_W'(MAX_SAMPLES)) begin
      co2_sum = co2_sum + CSUM_W'(req.carbon_dioxide);
      cnt_two = cnt_two + CNT_W'(1);
    end
  endtask

  function automatic out_item_t close_window();
    out_item_t               res;
    logic signed [TSUM_W:0]  t_num;
    logic signed [TSUM_W:0]  t_den;
    logic signed [TSUM_W:0]  t_quo;
    // an empty group keeps what it last reported
    if (cnt_one != '0) begin
      kept_avgs.avg_voc         = 13'(voc_sum / VSUM_W'(cnt_one));
      kept_avgs.avg_pm_one      = 16'(pm_sum[0] / PSUM_W'(cnt_one));
      kept_avgs.avg_pm_two_five = 16'(pm_sum[1] / PSUM_W'(cnt_one));
      kept_avgs.avg_pm_four     = 16'(pm_sum[2] / PSUM_W'(cnt_one));
      kept_avgs.avg_pm_ten      = 16'(pm_sum[3] / PSUM_W'(cnt_one));
      t_num = (TSUM_W + 1)'(temp_sum);
      t_den = (TSUM_W + 1)'({1'b0, cnt_one});
      t_quo = t_num / t_den;  // signed, truncates toward zero
      kept_avgs.avg_temperature = t_quo[15:0];
      kept_avgs.avg_humidity    = 14'(hum_sum / HSUM_W'(cnt_one));
    end
    if (cnt_two != '0) kept_avgs.avg_co2 = 16'(co2_sum / CSUM_W'(cnt_two));
    res             = kept_avgs;
    res.samples_one = SAMP_W'(cnt_one);
    res.samples_two = SAMP_W'(cnt_two);
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      clear_sums();
      kept_avgs = '0;
      pending_averages.delete();
      misses = 0;
      awaited_count <= 0;
    end else begin
      // result side first, so a close taken on this edge cannot mask a stray result
      if (out_valid && !out_stall) begin
        if (pending_averages.size() == 0) begin
          misses++;
          if (misses <= 10) $display("[%0t] result with no close request pending", $realtime);
        end else begin
          want = pending_averages.pop_front();
          if (out_data !== want) begin
            misses++;
            if (misses <= 10) begin
              $display("[%0t] want voc %0d pm %0d %0d %0d %0d t %0d h %0d co2 %0d n %0d %0d",
                       $realtime, want.avg_voc, want.avg_pm_one, want.avg_pm_two_five,
                       want.avg_pm_four, want.avg_pm_ten, $signed(want.avg_temperature),
                       want.avg_humidity, want.avg_co2, want.samples_one, want.samples_two);
              $display("[%0t] got  voc %0d pm %0d %0d %0d %0d t %0d h %0d co2 %0d n %0d %0d",
                       $realtime, out_data.avg_voc, out_data.avg_pm_one,
                       out_data.avg_pm_two_five, out_data.avg_pm_four, out_data.avg_pm_ten,
                       $signed(out_data.avg_temperature), out_data.avg_humidity,
                       out_data.avg_co2, out_data.samples_one, out_data.samples_two);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.action == ACT_CLOSE) begin
          pending_averages.push_back(close_window());
          clear_sums();
        end else begin
          fold_sample(in_data);
        end
      end
      awaited_count <= pending_averages.size();
    end
  end

endmodule

// File: verif/tb_windowed_sensor_averager_unit.sv
`timescale 1ns / 1ps

module tb_windowed_sensor_averager_unit;
  import wsa_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RAND_ITEMS   = 600;
  localparam int HOLD_CYCLES  = 1500;
  localparam int DRAIN_CYCLES = 300;
  localparam int LIMIT_CYCLES = 3_000_000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        mismatches;
  int        awaited;

  bit quiet;
  bit hold_req;
  bit hold_done;
  int gap_odds;
  int rand_items;

  windowed_sensor_averager_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  wsa_average_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .mismatch_count (mismatches),
    .awaited_count  (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(64'(LIMIT_CYCLES) * CLK_PERIOD);
    $display("tb_windowed_sensor_averager_unit: FAIL");
    $finish;
  end

  // edge-heavy value; callers keep the low bits they need
  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 16'h7FFF;
      3:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_acc(input logic v1, input logic v2);
    in_item_t req;
    req.action          = ACT_ACC;
    req.group_one_valid = v1;
    req.voc_index       = 13'(pick_value());
    req.pm_one          = pick_value();
    req.pm_two_five     = pick_value();
    req.pm_four         = pick_value();
    req.pm_ten          = pick_value();
    req.temperature     = pick_value();
    req.humidity        = 14'(pick_value());
    req.group_two_valid = v2;
    req.carbon_dioxide  = pick_value();
    return req;
  endfunction

  function automatic in_item_t acc_req(input logic v1, input logic [15:0] level,
                                       input logic signed [15:0] temp,
                                       input logic v2, input logic [15:0] co2);
    in_item_t req;
    req             = random_acc(v1, v2);
    req.voc_index   = 13'(level);
    req.pm_one      = level;
    req.pm_two_five = level;
    req.pm_four     = level;
    req.pm_ten      = level;
    req.humidity    = 14'(level);
    req.temperature = temp;
    req.carbon_dioxide = co2;
    return req;
  endfunction

  // close ignores flags and sample fields, so they are left random
  function automatic in_item_t close_req();
    in_item_t req;
    req        = random_acc(1'($urandom), 1'($urandom));
    req.action = ACT_CLOSE;
    return req;
  endfunction

  function automatic in_item_t noise_req();
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    return bits[$bits(in_item_t)-1:0];
  endfunction

  task automatic offer(input in_item_t req);
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (!quiet && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
  endtask

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  initial begin
    int  len;
    bit  g1_on;
    bit  g2_on;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    hold_done  = 1'b0;
    gap_odds   = 4;
    rand_items = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // empty window right after reset: zeros, both counts zero
    offer(close_req());
    // group one only, full-scale then zero with most negative temperature
    offer(acc_req(1'b1, 16'hFFFF, 16'sh7FFF, 1'b0, 16'hFFFF));
    offer(acc_req(1'b1, 16'h0000, -16'sd32768, 1'b0, 16'h0000));
    offer(close_req());
    // group two only; group one averages are kept
    offer(acc_req(1'b0, 16'h1234, 16'sd5, 1'b1, 16'hFFFF));
    offer(acc_req(1'b0, 16'h4321, -16'sd5, 1'b1, 16'h0000));
    offer(acc_req(1'b0, 16'hFFFF, 16'sd9, 1'b1, 16'h0001));
    offer(close_req());
    // no valid sample at all: everything kept
    offer(acc_req(1'b0, 16'hFFFF, -16'sd1, 1'b0, 16'hFFFF));
    offer(close_req());
    // negative sums truncate toward zero
    offer(acc_req(1'b1, 16'd3, -16'sd7, 1'b1, 16'd10));
    offer(acc_req(1'b1, 16'd4, -16'sd1, 1'b1, 16'd11));
    offer(acc_req(1'b1, 16'd5, 16'sd1, 1'b0, 16'd12));
    offer(close_req());
    offer(acc_req(1'b1, 16'd1, -16'sd1, 1'b1, 16'd1));
    offer(acc_req(1'b1, 16'd2, 16'sd0, 1'b1, 16'd2));
    offer(close_req());
    pause_until_drained();

    // both counters run into the limit; later samples must be dropped
    gap_odds = 0;
    repeat (MAX_SAMPLES + 8) offer(random_acc(1'b1, 1'b1));
    offer(close_req());
    pause_until_drained();

    while (rand_items < RAND_ITEMS) begin
      if (rand_items >= RAND_ITEMS - 100) quiet = 1'b1;
      gap_odds = ($urandom_range(0, 2) == 0) ? 0 : 4;
      if (!hold_req && rand_items >= 200) begin
        // long hold-off: closes pile up until the input stalls
        hold_req = 1'b1;
        repeat (3) begin
          repeat (2) offer(random_acc(1'b1, 1'b1));
          offer(close_req());
        end
        repeat (6) offer(random_acc(1'b1, 1'b1));
        rand_items += 15;
        pause_until_drained();
      end
      if ($urandom_range(0, 7) == 0) begin
        offer(noise_req());
        rand_items++;
      end else begin
        len   = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        g1_on = $urandom_range(0, 7) != 0;
        g2_on = $urandom_range(0, 7) != 0;
        repeat (len) begin
          offer(random_acc(g1_on && $urandom_range(0, 5) != 0,
                           g2_on && $urandom_range(0, 3) != 0));
          rand_items++;
        end
        offer(close_req());
        rand_items++;
      end
      if (!quiet && $urandom_range(0, 39) == 0) pause_until_drained();
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("tb_windowed_sensor_averager_unit: PASS");
    end else begin
      $display("tb_windowed_sensor_averager_unit: FAIL");
    end
    $finish;
  end

endmodule
